### sv/tpr_pkg.sv
package tpr_pkg;

	localparam int AXIS_W = 14;
	localparam int SQ_W = 27;
	localparam int SUM_W = 28;
	localparam int MAG_FRAC = 8;
	localparam int REM_W = SUM_W + 2 * MAG_FRAC;
	localparam int ROOT_W = 23;
	localparam int NUM_W = 15;
	localparam int COORD_W = 26;
	localparam int ACC_W = 28;
	localparam int ANG_FRAC = 12;
	localparam int ANGLE_W = 15;
	localparam int ANGLE_LIMIT = 9000;
	localparam int CORDIC_STAGES = 16;
	localparam int ANG_TABLE_LEN = 24;
	localparam int NSTG = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES : ANG_TABLE_LEN;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [REM_W-1:0] rem_t;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	function automatic acc_t atan_step(input int i);
		acc_t r;
		case (i)
			0: r = ACC_W'(18432000);
			1: r = ACC_W'(10881045);
			2: r = ACC_W'(5749245);
			3: r = ACC_W'(2918407);
			4: r = ACC_W'(1464867);
			5: r = ACC_W'(733147);
			6: r = ACC_W'(366663);
			7: r = ACC_W'(183343);
			8: r = ACC_W'(91673);
			9: r = ACC_W'(45837);
			10: r = ACC_W'(22918);
			11: r = ACC_W'(11459);
			12: r = ACC_W'(5730);
			13: r = ACC_W'(2865);
			14: r = ACC_W'(1432);
			15: r = ACC_W'(716);
			16: r = ACC_W'(358);
			17: r = ACC_W'(179);
			18: r = ACC_W'(90);
			19: r = ACC_W'(45);
			20: r = ACC_W'(22);
			21: r = ACC_W'(11);
			22: r = ACC_W'(6);
			23: r = ACC_W'(3);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/tpr_sqrt.sv
module tpr_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  tpr_pkg::sum_t  in_sum,
	input  tpr_pkg::num_t  in_num,
	output logic           out_valid,
	output tpr_pkg::root_t out_root,
	output tpr_pkg::num_t  out_num
);
	import tpr_pkg::*;

	rem_t  rem_s  [0:ROOT_W];
	root_t root_s [0:ROOT_W];
	num_t  num_s  [0:ROOT_W];
	logic [ROOT_W:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {in_sum, {(2 * MAG_FRAC){1'b0}}};
			root_s[0] <= '0;
			num_s[0] <= in_num;
		end
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
		localparam int B = ROOT_W - 1 - i;
		logic [REM_W:0] trial;
		logic ge;

		assign trial = ((REM_W + 1)'(root_s[i]) << (B + 1)) | ((REM_W + 1)'(1) << (2 * B));
		assign ge = {1'b0, rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (rem_s[i] - trial[REM_W-1:0]) : rem_s[i];
				root_s[i+1] <= ge ? (root_s[i] | (ROOT_W'(1) << B)) : root_s[i];
				num_s[i+1] <= num_s[i];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_num = num_s[ROOT_W];

endmodule

### sv/tpr_cordic.sv
module tpr_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tpr_pkg::root_t  in_mag,
	input  tpr_pkg::num_t   in_num,
	output logic            out_valid,
	output tpr_pkg::angle_t out_angle
);
	import tpr_pkg::*;

	coord_t cx_s  [0:NSTG];
	coord_t cy_s  [0:NSTG];
	acc_t   acc_s [0:NSTG];
	logic [NSTG:0] neg_s;
	logic [NSTG:0] numz_s;
	logic [NSTG:0] magz_s;
	logic [NSTG:0] vld_s;
	logic   vld_q;
	angle_t angle_q;
	num_t   ny;
	acc_t   rnd;
	logic [ANGLE_W-1:0] mag_res;
	logic [ANGLE_W-1:0] res;

	assign ny = in_num[NUM_W-1] ? -in_num : in_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= COORD_W'(in_mag);
			cy_s[0] <= COORD_W'(ny) <<< MAG_FRAC;
			acc_s[0] <= '0;
			neg_s[0] <= in_num[NUM_W-1];
			numz_s[0] <= (in_num == '0);
			magz_s[0] <= (in_mag == '0);
		end
	end

	for (genvar i = 0; i < NSTG; i++) begin : g_iter
		coord_t dx;
		coord_t dy;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][COORD_W-1]) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + atan_step(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - atan_step(i);
				end
				neg_s[i+1] <= neg_s[i];
				numz_s[i+1] <= numz_s[i];
				magz_s[i+1] <= magz_s[i];
			end
		end
	end

	always_comb begin
		rnd = (acc_s[NSTG] + ACC_W'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
		if (rnd[ACC_W-1]) begin
			mag_res = '0;
		end else if (rnd > ACC_W'(ANGLE_LIMIT)) begin
			mag_res = ANGLE_W'(ANGLE_LIMIT);
		end else begin
			mag_res = rnd[ANGLE_W-1:0];
		end
		if (numz_s[NSTG]) begin
			res = '0;
		end else if (magz_s[NSTG]) begin
			res = ANGLE_W'(ANGLE_LIMIT);
		end else begin
			res = mag_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= neg_s[NSTG] ? -angle_t'(res) : angle_t'(res);
		end
	end

	assign out_valid = vld_q;
	assign out_angle = angle_q;

endmodule

### sv/accel_tilt_pitch_roll_unit.sv
// Throughput: one beat per cycle while the output is not stalled; the squaring, the one-bit-per-stage square root
// and the 16-stage CORDIC are all fully pipelined.
// The pipeline advances whenever the output register is empty or being taken.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module accel_tilt_pitch_roll_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // pitch_angle, roll_angle, zero pad
);
	import tpr_pkg::*;

	logic  en;
	axis_t ax;
	axis_t ay;
	axis_t az;
	sq_t   xx_s1;
	sq_t   yy_s1;
	sq_t   zz_s1;
	num_t  pnum_s1;
	num_t  rnum_s1;
	logic  vld_s1;
	logic  p_sq_vld;
	logic  r_sq_vld;
	root_t p_mag;
	root_t r_mag;
	num_t  p_num;
	num_t  r_num;
	logic  p_vld;
	logic  r_vld;
	angle_t pitch;
	angle_t roll;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	assign ax = s_axis_tdata[13:0];
	assign ay = s_axis_tdata[27:14];
	assign az = s_axis_tdata[41:28];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= SQ_W'(28'(ax * ax));
			yy_s1 <= SQ_W'(28'(ay * ay));
			zz_s1 <= SQ_W'(28'(az * az));
			pnum_s1 <= NUM_W'(ay);
			rnum_s1 <= -NUM_W'(ax);
		end
	end

	tpr_sqrt u_sqrt_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.in_sum   (SUM_W'(xx_s1) + SUM_W'(zz_s1)),
		.in_num   (pnum_s1),
		.out_valid(p_sq_vld),
		.out_root (p_mag),
		.out_num  (p_num)
	);

	tpr_sqrt u_sqrt_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.in_sum   (SUM_W'(yy_s1) + SUM_W'(zz_s1)),
		.in_num   (rnum_s1),
		.out_valid(r_sq_vld),
		.out_root (r_mag),
		.out_num  (r_num)
	);

	tpr_cordic u_cordic_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (p_sq_vld),
		.in_mag   (p_mag),
		.in_num   (p_num),
		.out_valid(p_vld),
		.out_angle(pitch)
	);

	tpr_cordic u_cordic_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_sq_vld),
		.in_mag   (r_mag),
		.in_num   (r_num),
		.out_valid(r_vld),
		.out_angle(roll)
	);

	assign m_axis_tvalid = p_vld && r_vld;
	assign m_axis_tdata = {2'b00, roll, pitch};

endmodule

### tb/accel_tilt_pitch_roll_unit_tb.sv
`timescale 1ns / 100ps

module accel_tilt_pitch_roll_unit_tb;
	import tpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PIPE_LATENCY = 43;
	localparam int N_RANDOM = 1750;

	typedef struct packed {
		angle_t roll;
		angle_t pitch;
	} tilt_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	logic [47:0] sample_q[$];
	tilt_t       tilt_q[$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          idle_cycles = 0;
	bit          stim_done = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          hold_off = 0;
	bit          hold_done = 0;
	bit          in_taken = 0;

	accel_tilt_pitch_roll_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic longint floor_div_pow2(longint v, int s);
		if (v >= 0) begin
			return v >>> s;
		end
		return -((~v) >>> s) - 1;
	endfunction

	function automatic longint atan_entry(int i);
		longint tab[24] = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147,
			366663, 183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
			358, 179, 90, 45, 22, 11, 6, 3};
		return tab[i];
	endfunction

	function automatic longint vector_length(longint a, longint b);
		longint sq;
		longint root;
		longint t;
		sq = (a * a + b * b) << 16;
		root = 0;
		for (int bit_i = 22; bit_i >= 0; bit_i--) begin
			t = root | (longint'(1) << bit_i);
			if (t * t <= sq) begin
				root = t;
			end
		end
		return root;
	endfunction

	function automatic angle_t tilt_of(longint num, longint mag);
		bit     neg;
		longint ny;
		longint cx;
		longint cy;
		longint acc;
		longint dx;
		longint dy;
		longint res;
		neg = num < 0;
		ny = neg ? -num : num;
		if (ny == 0) begin
			return '0;
		end
		if (mag == 0) begin
			return neg ? angle_t'(-ANGLE_LIMIT) : angle_t'(ANGLE_LIMIT);
		end
		cx = mag;
		cy = ny << 8;
		acc = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = floor_div_pow2(cy, i);
			dy = floor_div_pow2(cx, i);
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				acc += atan_entry(i);
			end else begin
				cx -= dx;
				cy += dy;
				acc -= atan_entry(i);
			end
		end
		res = floor_div_pow2(acc + 2048, 12);
		if (res < 0) begin
			res = 0;
		end
		if (res > ANGLE_LIMIT) begin
			res = ANGLE_LIMIT;
		end
		return neg ? angle_t'(-res) : angle_t'(res);
	endfunction

	function automatic tilt_t predict_tilt(logic [47:0] beat);
		axis_t ax;
		axis_t ay;
		axis_t az;
		tilt_t r;
		ax = beat[13:0];
		ay = beat[27:14];
		az = beat[41:28];
		r.pitch = tilt_of(longint'(ay), vector_length(longint'(ax), longint'(az)));
		r.roll = tilt_of(-longint'(ax), vector_length(longint'(ay), longint'(az)));
		return r;
	endfunction

	function automatic logic [47:0] pack_sample(int x, int y, int z);
		return {6'b0, 14'(z), 14'(y), 14'(x)};
	endfunction

	function automatic int rand_axis();
		int corners[6] = '{-8192, 8191, 0, 1, -1, -8191};
		case ($urandom_range(0, 5))
			0: return corners[$urandom_range(0, 5)];
			1: return $signed($urandom_range(0, 64)) - 32;
			default: return $signed($urandom_range(0, 16383)) - 8192;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	initial begin
		int ext[4] = '{-8192, 8191, 0, 1};
		int rx;
		int ry;
		int rz;
		for (int i = 0; i < 4; i++) begin
			sample_q.push_back(pack_sample(ext[i], 0, 0));
			sample_q.push_back(pack_sample(0, ext[i], 0));
			sample_q.push_back(pack_sample(0, 0, ext[i]));
		end
		sample_q.push_back(pack_sample(0, 0, 0));
		sample_q.push_back(pack_sample(-8192, -8192, -8192));
		sample_q.push_back(pack_sample(8191, 8191, 8191));
		sample_q.push_back(pack_sample(-8192, 8191, 0));
		sample_q.push_back(pack_sample(1, -1, 8191));
		sample_q.push_back(pack_sample(-1, 1, -8192));
		sample_q.push_back(pack_sample(5000, -3000, 1));
		sample_q.push_back(pack_sample(-8192, 8191, -8192));
		for (int i = 0; i < N_RANDOM; i++) begin
			rx = rand_axis();
			ry = rand_axis();
			rz = rand_axis();
			sample_q.push_back(pack_sample(rx, ry, rz));
		end
		stim_done = 1;
	end

	// Sender: a new beat is offered after a random gap; the gap can be zero.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= $urandom_range(0, 11);
		end else if (s_axis_tvalid && !in_taken) begin
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (sample_q.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= sample_q.pop_front();
			send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// A gap only starts after the current beat was taken, hence the handshake check.
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			tilt_q.push_back(predict_tilt(s_axis_tdata));
		end
	end

	// Receiver: random stalls, plus one long hold-off so the pipeline backs up.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else if (!hold_done && tilt_q.size() > 20) begin
			m_axis_tready <= 1'b0;
			if (hold_off == 300) begin
				hold_done <= 1;
			end
			hold_off <= hold_off + 1;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (m_axis_tvalid) begin
				recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
			end
		end
	end

	always @(posedge clk) begin
		tilt_t got;
		tilt_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[29:0];
			if (tilt_q.size() == 0) begin
				$error("unexpected output beat %h", m_axis_tdata);
				n_errors++;
			end else begin
				want = tilt_q.pop_front();
				if (got.pitch !== want.pitch) begin
					$error("pitch_angle expected %0d got %0d", want.pitch, got.pitch);
					n_errors++;
				end
				if (got.roll !== want.roll) begin
					$error("roll_angle expected %0d got %0d", want.roll, got.roll);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (stim_done && sample_q.size() == 0 && !s_axis_tvalid
					&& tilt_q.size() == 0);
				repeat (PIPE_LATENCY + 20) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG_LIMIT);
		join_any
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("accel_tilt_pitch_roll_unit_tb: done, errors");
			$finish;
		end else begin
			$display("Checked %0d tilt results from directed corners and random samples,",
				n_checked);
			$display("with random stalls on both sides and one long output hold-off.");
			if (n_errors == 0 && tilt_q.size() == 0) begin
				$display("accel_tilt_pitch_roll_unit_tb: done, clean");
			end else begin
				$display("accel_tilt_pitch_roll_unit_tb: done, errors");
			end
			$finish;
		end
	end

endmodule
